@@ src/clock_control_register_block_unit_assert.svh @@
// assertion macros for the clock control register block
`ifndef CLOCK_CONTROL_REGISTER_BLOCK_UNIT_ASSERT_SVH
`define CLOCK_CONTROL_REGISTER_BLOCK_UNIT_ASSERT_SVH

// same-cycle implication
`define CCRB_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCRB_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ccrb_pkg.sv @@
// types, constants and helpers shared by the clock control register block
package ccrb_pkg;

  localparam int DIV_W = 33;
  localparam int DVS_W = 5;

  localparam logic [5:0] W_CTRL     = 6'd0;
  localparam logic [5:0] W_CFG      = 6'd2;
  localparam logic [5:0] W_PLL      = 6'd3;
  localparam logic [5:0] W_FLAGS    = 6'd7;
  localparam logic [5:0] W_CLEAR    = 6'd8;
  localparam logic [5:0] W_BACKUP   = 6'd36;
  localparam logic [5:0] W_LOWSPEED = 6'd37;
  localparam logic [5:0] W_OSC48    = 6'd38;

  localparam logic [31:0] CTRL_RESET = 32'h0000_0500;
  localparam logic [31:0] CFG_RESET  = 32'h0000_0005;

  localparam logic [31:0] HZ_4M     = 32'd4000000;
  localparam logic [31:0] HZ_16M    = 32'd16000000;
  localparam logic [25:0] HSE_RESET = 26'd8000000;

  localparam logic [1:0] SEL_MSI = 2'd0;
  localparam logic [1:0] SEL_HSI = 2'd1;
  localparam logic [1:0] SEL_HSE = 2'd2;
  localparam logic [1:0] SEL_PLL = 2'd3;

  localparam logic [1:0] PSRC_NONE = 2'd0;
  localparam logic [1:0] PSRC_MSI  = 2'd1;
  localparam logic [1:0] PSRC_HSI  = 2'd2;
  localparam logic [1:0] PSRC_HSE  = 2'd3;

  localparam logic CFG_EXT_FITTED = 1'b0;
  localparam logic CFG_HSE_FREQ   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPLY,
    S_READ,
    S_SELECT,
    S_DIV1,
    S_MUL,
    S_DIV2,
    S_CMP,
    S_DONE
  } ccrb_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } ccrb_div_req_t;

  function automatic logic [31:0] refresh_ctrl(input logic [31:0] v, input logic hse);
    logic [31:0] r;
    r     = v;
    r[1]  = v[0];
    r[10] = v[8];
    r[17] = v[16] & hse;
    r[25] = v[24];
    return r;
  endfunction

  function automatic logic [31:0] refresh_low(input logic [31:0] v);
    logic [31:0] r;
    r    = v;
    r[1] = v[0];
    return r;
  endfunction

endpackage

@@ src/ccrb_div.sv @@
// shared restoring divider, one quotient bit per cycle
module ccrb_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ccrb_pkg::ccrb_div_req_t               req,
  output logic                                  div_done,
  output logic [ccrb_pkg::DIV_W-1:0]            quotient
);

  logic [ccrb_pkg::DIV_W-1:0] quo;
  logic [ccrb_pkg::DVS_W-1:0] rem;
  logic [ccrb_pkg::DVS_W-1:0] dvs;
  logic [5:0]                 cnt;
  logic                       active;
  logic                       done_q;
  logic [ccrb_pkg::DVS_W:0]   trial;
  logic                       fits;

  assign trial = {rem, quo[ccrb_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else begin
      done_q <= active && !req.start && (cnt == 6'd1);
      if (req.start) begin
        active <= 1'b1;
        cnt    <= 6'(ccrb_pkg::DIV_W);
      end else if (active) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (active) begin
      quo <= {quo[ccrb_pkg::DIV_W-2:0], fits};
      rem <= fits ? ccrb_pkg::DVS_W'(trial - {1'b0, dvs}) : trial[ccrb_pkg::DVS_W-1:0];
    end
  end

  assign div_done = done_q;
  assign quotient = quo;

endmodule

@@ src/ccrb_ram.sv @@
// general register word storage with per-word valid bits, registered read
module ccrb_ram #(
  parameter int DEPTH = 40,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [31:0]    mem_q;
  logic           valid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      valid_q <= valid[raddr];
    end
  end

  assign rdata = valid_q ? mem_q : 32'd0;

endmodule

@@ src/clock_control_register_block_unit.sv @@
// top level of the clock control register block with access sequencer
//
// Usage: pulse start with kind, byte_offset and write_data while busy is low;
// the request is taken at that edge and busy stays high until the result.
// The result (read_data, system_clock_hz, clock_changed) is shown for one
// cycle with done high; the receiver has no way to hold it off.
// read_data is the addressed word after the access; words at or past
// REGISTER_WORDS read as zero and ignore writes.
// Reads and most writes pass apply, read and done; writes to the control,
// configuration or PLL words also pass select and compare, and when the
// PLL is selected with a source, the frequency is recomputed between them.
// The PLL path runs two passes of one shared divider at one quotient bit
// per cycle with a multiply in between. The next request is taken from the
// cycle after done.
// Configuration writes (cfg_write_en, cfg_index, cfg_data) take effect at
// once and should happen while busy is low.
// Reset restores the register reset values, a 16 MHz system clock, no
// external oscillator and an 8 MHz external frequency setting.
module clock_control_register_block_unit #(
  parameter int REGISTER_WORDS = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [25:0] cfg_data,
  input  logic        start,
  input  logic        kind,
  input  logic [7:0]  byte_offset,
  input  logic [31:0] write_data,
  output logic        busy,
  output logic        done,
  output logic [31:0] read_data,
  output logic [31:0] system_clock_hz,
  output logic        clock_changed
);

`include "clock_control_register_block_unit_assert.svh"

  localparam int AW = $clog2(REGISTER_WORDS);
  localparam logic [6:0] WORDS = 7'(REGISTER_WORDS);

  ccrb_pkg::ccrb_state_t state, state_next;
  ccrb_pkg::ccrb_div_req_t div_req;

  logic        div_done;
  logic [ccrb_pkg::DIV_W-1:0] quotient;

  logic        ext_fitted;
  logic [25:0] hse_freq;
  logic [31:0] ctrl, cfg, pll, flags, bkp, lsr, o48;
  logic [31:0] cur_hz;
  logic        changed;

  logic        req_kind;
  logic [5:0]  req_word;
  logic [31:0] req_data;
  logic [31:0] rd;
  logic [25:0] q1;
  logic [31:0] next_hz;

  logic        in_range;
  logic        is_write;
  logic        special;
  logic        clock_word;
  logic        use_pll_div;
  logic [31:0] ram_rdata;
  logic        ram_we;
  logic [25:0] ext_hz;
  logic [25:0] pll_src;
  logic [4:0]  pll_m;
  logic [6:0]  pll_n;
  logic [3:0]  pll_r;
  logic [31:0] sel_hz;
  logic [31:0] ctrl_w, bkp_w, lsr_w, o48_w;

  assign in_range = {1'b0, req_word} < WORDS;
  assign is_write = req_kind && in_range;
  assign special  = (req_word == ccrb_pkg::W_CTRL) || (req_word == ccrb_pkg::W_CFG) ||
                    (req_word == ccrb_pkg::W_PLL) || (req_word == ccrb_pkg::W_FLAGS) ||
                    (req_word == ccrb_pkg::W_CLEAR) || (req_word == ccrb_pkg::W_BACKUP) ||
                    (req_word == ccrb_pkg::W_LOWSPEED) || (req_word == ccrb_pkg::W_OSC48);
  assign clock_word = is_write && ((req_word == ccrb_pkg::W_CTRL) ||
                      (req_word == ccrb_pkg::W_CFG) || (req_word == ccrb_pkg::W_PLL));
  assign ram_we = (state == ccrb_pkg::S_APPLY) && is_write && !special;

  assign ext_hz = (hse_freq == 26'd0) ? ccrb_pkg::HSE_RESET : hse_freq;
  assign pll_m  = {1'b0, pll[7:4]} + 5'd1;
  assign pll_n  = (pll[14:8] == 7'd0) ? 7'd1 : pll[14:8];
  assign pll_r  = {({1'b0, pll[26:25]} + 3'd1), 1'b0};

  assign ctrl_w = (req_word == ccrb_pkg::W_CTRL)     ? req_data : ctrl;
  assign bkp_w  = (req_word == ccrb_pkg::W_BACKUP)   ? req_data : bkp;
  assign lsr_w  = (req_word == ccrb_pkg::W_LOWSPEED) ? req_data : lsr;
  assign o48_w  = (req_word == ccrb_pkg::W_OSC48)    ? req_data : o48;

  always_comb begin
    pll_src = ccrb_pkg::HZ_16M[25:0];
    case (pll[1:0])
      ccrb_pkg::PSRC_MSI: pll_src = ccrb_pkg::HZ_4M[25:0];
      ccrb_pkg::PSRC_HSE: pll_src = ext_hz;
      default:            pll_src = ccrb_pkg::HZ_16M[25:0];
    endcase
  end

  always_comb begin
    use_pll_div = 1'b0;
    sel_hz      = ccrb_pkg::HZ_16M;
    unique case (cfg[1:0])
      ccrb_pkg::SEL_MSI: sel_hz = ccrb_pkg::HZ_4M;
      ccrb_pkg::SEL_HSI: sel_hz = ccrb_pkg::HZ_16M;
      ccrb_pkg::SEL_HSE: sel_hz = ext_fitted ? 32'(ext_hz) : ccrb_pkg::HZ_16M;
      ccrb_pkg::SEL_PLL: use_pll_div = (pll[1:0] != ccrb_pkg::PSRC_NONE);
      default:           sel_hz = ccrb_pkg::HZ_16M;
    endcase
  end

  ccrb_ram #(
    .DEPTH(REGISTER_WORDS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .rst  (rst),
    .we   (ram_we),
    .waddr(req_word[AW-1:0]),
    .wdata(req_data),
    .raddr(req_word[AW-1:0]),
    .rdata(ram_rdata)
  );

  ccrb_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (div_req),
    .div_done(div_done),
    .quotient(quotient)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ccrb_pkg::S_IDLE:   if (start) state_next = ccrb_pkg::S_APPLY;
      ccrb_pkg::S_APPLY:  state_next = ccrb_pkg::S_READ;
      ccrb_pkg::S_READ:   state_next = clock_word ? ccrb_pkg::S_SELECT : ccrb_pkg::S_DONE;
      ccrb_pkg::S_SELECT: state_next = use_pll_div ? ccrb_pkg::S_DIV1 : ccrb_pkg::S_CMP;
      ccrb_pkg::S_DIV1:   if (div_done) state_next = ccrb_pkg::S_MUL;
      ccrb_pkg::S_MUL:    state_next = ccrb_pkg::S_DIV2;
      ccrb_pkg::S_DIV2:   if (div_done) state_next = ccrb_pkg::S_CMP;
      ccrb_pkg::S_CMP:    state_next = ccrb_pkg::S_DONE;
      ccrb_pkg::S_DONE:   state_next = ccrb_pkg::S_IDLE;
      default:            state_next = ccrb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy             = (state != ccrb_pkg::S_IDLE);
    done             = (state == ccrb_pkg::S_DONE);
    clock_changed    = done && changed;
    div_req.start    = 1'b0;
    div_req.dividend = {7'd0, pll_src};
    div_req.divisor  = pll_m;
    unique case (state)
      ccrb_pkg::S_SELECT: div_req.start = use_pll_div;
      ccrb_pkg::S_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = {7'd0, q1} * {26'd0, pll_n};
        div_req.divisor  = {1'b0, pll_r};
      end
      default: div_req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccrb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_fitted <= 1'b0;
      hse_freq   <= ccrb_pkg::HSE_RESET;
      ctrl       <= ccrb_pkg::CTRL_RESET;
      cfg        <= ccrb_pkg::CFG_RESET;
      pll        <= '0;
      flags      <= '0;
      bkp        <= '0;
      lsr        <= '0;
      o48        <= '0;
      cur_hz     <= ccrb_pkg::HZ_16M;
      changed    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          ccrb_pkg::CFG_EXT_FITTED: ext_fitted <= cfg_data[0];
          ccrb_pkg::CFG_HSE_FREQ:   hse_freq   <= cfg_data;
          default:                  ext_fitted <= ext_fitted;
        endcase
      end
      if (state == ccrb_pkg::S_IDLE && start) begin
        changed <= 1'b0;
      end
      if (state == ccrb_pkg::S_APPLY && is_write) begin
        unique case (req_word) inside
          ccrb_pkg::W_CTRL, ccrb_pkg::W_BACKUP, ccrb_pkg::W_LOWSPEED, ccrb_pkg::W_OSC48: begin
            ctrl <= ccrb_pkg::refresh_ctrl(ctrl_w, ext_fitted);
            bkp  <= ccrb_pkg::refresh_low(bkp_w);
            lsr  <= ccrb_pkg::refresh_low(lsr_w);
            o48  <= ccrb_pkg::refresh_low(o48_w);
          end
          ccrb_pkg::W_CFG:   cfg   <= {req_data[31:4], req_data[1:0], req_data[1:0]};
          ccrb_pkg::W_PLL:   pll   <= req_data;
          ccrb_pkg::W_FLAGS: flags <= req_data;
          ccrb_pkg::W_CLEAR: flags <= flags & ~req_data;
          default:           flags <= flags;
        endcase
      end
      if (state == ccrb_pkg::S_CMP && next_hz != 32'd0 && next_hz != cur_hz) begin
        cur_hz  <= next_hz;
        changed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ccrb_pkg::S_IDLE && start) begin
      req_kind <= kind;
      req_word <= byte_offset[7:2];
      req_data <= write_data;
    end
    if (state == ccrb_pkg::S_READ) begin
      if (!in_range) begin
        rd <= 32'd0;
      end else begin
        unique case (req_word)
          ccrb_pkg::W_CTRL:     rd <= ctrl;
          ccrb_pkg::W_CFG:      rd <= cfg;
          ccrb_pkg::W_PLL:      rd <= pll;
          ccrb_pkg::W_FLAGS:    rd <= flags;
          ccrb_pkg::W_CLEAR:    rd <= 32'd0;
          ccrb_pkg::W_BACKUP:   rd <= bkp;
          ccrb_pkg::W_LOWSPEED: rd <= lsr;
          ccrb_pkg::W_OSC48:    rd <= o48;
          default:              rd <= req_kind ? req_data : ram_rdata;
        endcase
      end
    end
    if (state == ccrb_pkg::S_SELECT) begin
      next_hz <= sel_hz;
    end
    if (state == ccrb_pkg::S_DIV1 && div_done) begin
      q1 <= quotient[25:0];
    end
    if (state == ccrb_pkg::S_DIV2 && div_done) begin
      next_hz <= quotient[31:0];
    end
  end

  assign read_data       = rd;
  assign system_clock_hz = cur_hz;

  `CCRB_ASSERT_IMP(a_done_in_request, clk, rst, done, busy, "result strobe outside a request")
  `CCRB_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy && !done, "request not held")
  `CCRB_ASSERT_IMP(a_change_with_done, clk, rst, clock_changed, done, "clock change without result")
  `CCRB_ASSERT_IMP(a_change_moves, clk, rst, done && clock_changed, system_clock_hz != $past(system_clock_hz), "clock change with same frequency")
  `CCRB_ASSERT_IMP(a_div_expected, clk, rst, div_done, state == ccrb_pkg::S_DIV1 || state == ccrb_pkg::S_DIV2, "divider finished out of sequence")

endmodule
